>>> rtl/core/lgs_pkg.sv
package lgs_pkg;

  // grid size
  localparam int ROWS = 32;
  localparam int COLS = 32;

  // row address and column index widths
  localparam int RA_W = $clog2(ROWS);
  localparam int CA_W = $clog2(COLS);

  // request field widths
  localparam int OP_W  = 2;
  localparam int POS_W = 5;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] KEEP_CNT  = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_FILL,
    ST_SWEEP
  } state_t;

endpackage

>>> rtl/core/lgs_ram.sv
module lgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/life_grid_generation_step.sv
// A cell read or write reads its row when taken and gives its result from the cell state;
//   an unused op code or an off-grid cell gives it straight from idle. Results are registered.
// An advance sweeps the grid one row per cycle and gives its result on the last row.
// A new request waits until the last one is through and the result slot is free, set by
//   the single row-wide grid memory (one read and one write port).
// Reset: synchronous, active low; per-row valid flags clear so the grid reads dead at once.
module life_grid_generation_step
  import lgs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_op,
  input  logic [POS_W-1:0] in_row,
  input  logic [POS_W-1:0] in_col,
  input  logic             in_cell_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_read_value,
  output logic             out_step_done
);

  // Grid storage: one memory word per row, bit c is column c.
  // A row that has never been written reads as all dead via its valid flag.

  state_t state_r, state_nxt;

  logic            in_acc;
  logic            on_grid;

  // memory ports
  logic            wr_en;
  logic [RA_W-1:0] wr_addr;
  logic [COLS-1:0] wr_data;
  logic            rd_en;
  logic [RA_W-1:0] rd_addr;
  logic [COLS-1:0] rd_data;

  // row valid flags, and the flag of the row being read
  logic [ROWS-1:0] row_vld_r;
  logic            rd_vld_r;
  logic [COLS-1:0] rd_row;

  // latched cell request
  logic            is_wr_r, is_wr_nxt;
  logic [RA_W-1:0] addr_r, addr_nxt;
  logic [CA_W-1:0] col_r, col_nxt;
  logic            val_r, val_nxt;

  // sweep window: row above, current row, row below
  logic [RA_W-1:0] row_r, row_nxt;
  logic [COLS-1:0] up_r, up_nxt;
  logic [COLS-1:0] mid_r, mid_nxt;
  logic [COLS-1:0] down;
  logic [COLS-1:0] new_row;
  logic [COLS+1:0] up_p, mid_p, dn_p;
  logic            last_row;
  logic            more_rows;

  // result register
  logic            res_valid;
  logic            res_read;
  logic            res_step;
  logic            out_valid_r;
  logic            out_read_value_r;
  logic            out_step_done_r;

  function automatic logic life_cell(input logic [2:0] a, input logic [2:0] m,
                                     input logic [2:0] b);
    logic [3:0] n;
    n = 4'(a[0]) + 4'(a[1]) + 4'(a[2]) + 4'(m[0]) + 4'(m[2])
      + 4'(b[0]) + 4'(b[1]) + 4'(b[2]);
    return (n == BIRTH_CNT) || (m[1] && (n == KEEP_CNT));
  endfunction

  // busy while a request is in flight, or the result slot stays full
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign on_grid  = (int'(in_row) < ROWS) && (int'(in_col) < COLS);

  assign rd_row    = rd_vld_r ? rd_data : '0;
  assign last_row  = (row_r == RA_W'(ROWS - 1));
  assign more_rows = (int'(row_r) + 2) < ROWS;
  // past the bottom edge everything is dead
  assign down      = last_row ? '0 : rd_row;

  assign up_p  = {1'b0, up_r, 1'b0};
  assign mid_p = {1'b0, mid_r, 1'b0};
  assign dn_p  = {1'b0, down, 1'b0};

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      new_row[c] = life_cell(up_p[c +: 3], mid_p[c +: 3], dn_p[c +: 3]);
    end
  end

  lgs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op) inside
            OP_WRITE, OP_READ: state_nxt = on_grid ? ST_CELL : ST_IDLE;
            OP_STEP:           state_nxt = ST_FILL;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CELL:  state_nxt = ST_IDLE;
      ST_FILL:  state_nxt = ST_SWEEP;
      ST_SWEEP: state_nxt = last_row ? ST_IDLE : ST_SWEEP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = addr_r;
    wr_data   = rd_row;
    rd_en     = 1'b0;
    rd_addr   = RA_W'(in_row);
    res_valid = 1'b0;
    res_read  = 1'b0;
    res_step  = 1'b0;
    is_wr_nxt = is_wr_r;
    addr_nxt  = addr_r;
    col_nxt   = col_r;
    val_nxt   = val_r;
    row_nxt   = row_r;
    up_nxt    = up_r;
    mid_nxt   = mid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          is_wr_nxt = (in_op == OP_WRITE);
          addr_nxt  = RA_W'(in_row);
          col_nxt   = CA_W'(in_col);
          val_nxt   = in_cell_value;
          row_nxt   = '0;
          unique case (in_op) inside
            OP_WRITE, OP_READ: begin
              rd_en     = on_grid;
              res_valid = !on_grid;
            end
            OP_STEP: begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      ST_CELL: begin
        // row is back from memory: patch one bit for a write, pick it for a read
        wr_en          = is_wr_r;
        wr_data[col_r] = val_r;
        res_valid      = 1'b1;
        res_read       = !is_wr_r && rd_row[col_r];
      end
      ST_FILL: begin
        // row 0 arrives; nothing above it
        up_nxt  = '0;
        mid_nxt = rd_row;
        rd_en   = 1'b1;
        rd_addr = RA_W'(1);
      end
      ST_SWEEP: begin
        // rewrite row in place; the old contents live on in the window
        wr_en   = 1'b1;
        wr_addr = row_r;
        wr_data = new_row;
        up_nxt  = mid_r;
        mid_nxt = down;
        row_nxt = row_r + RA_W'(1);
        rd_en   = more_rows;
        rd_addr = row_r + RA_W'(2);
        if (last_row) begin
          res_valid = 1'b1;
          res_step  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= row_vld_r[rd_addr];
    end
    if (res_valid) begin
      out_read_value_r <= res_read;
      out_step_done_r  <= res_step;
    end
    is_wr_r <= is_wr_nxt;
    addr_r  <= addr_nxt;
    col_r   <= col_nxt;
    val_r   <= val_nxt;
    row_r   <= row_nxt;
    up_r    <= up_nxt;
    mid_r   <= mid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_step_done  = out_step_done_r;

endmodule

>>> rtl/core/lgs_chk.sv
module lgs_chk
  import lgs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [OP_W-1:0]  in_op,
  input logic [POS_W-1:0] in_row,
  input logic [POS_W-1:0] in_col,
  input logic             in_cell_value,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_read_value,
  input logic             out_step_done
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a held result keeps its fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_step_done))
    else $error("stalled result changed");

  // a result never carries both a cell value and an advance flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_value && out_step_done))
    else $error("read value and step done both set");

  // an advance keeps the input side busy
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_STEP) |=> in_stall)
    else $error("request taken during advance");

  // an unused op code answers at once with an empty result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op != OP_WRITE) && (in_op != OP_READ) && (in_op != OP_STEP)
      |=> out_valid && !out_read_value && !out_step_done)
    else $error("unused op code gave wrong result");

  // an on-grid cell request takes its memory turn before anything else enters
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ((in_op == OP_WRITE) || (in_op == OP_READ))
      && (int'(in_row) < ROWS) && (int'(in_col) < COLS) |=> in_stall)
    else $error("request taken during cell access");

endmodule

bind life_grid_generation_step lgs_chk u_lgs_chk (.*);

>>> sim/tb_life_grid_generation_step.sv
`timescale 1ns / 1ps

module tb_life_grid_generation_step;
  import lgs_pkg::*;

  // op code the block must treat as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // cycles with no request or reply taken before we give up; it allows for an
  // advance plus sender gap and sink stall, with a wide margin
  localparam int QUIET_LIMIT = 40 * (ROWS + 2 + 8 + 8);
  localparam int TARGET_REQS = 1500;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             cell_value;
    bit               drain;  // hold this request back until all replies are in
    bit               calm;   // no sender gap after this request
  } cell_req_t;

  typedef struct {
    logic read_value;
    logic step_done;
  } cell_reply_t;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_op         = '0;
  logic [POS_W-1:0] in_row        = '0;
  logic [POS_W-1:0] in_col        = '0;
  logic             in_cell_value = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic             out_read_value;
  logic             out_step_done;

  // requests still to be driven, and replies the grid model says are owed
  cell_req_t   req_pending[$];
  cell_reply_t cell_reply_q[$];

  // our own copy of the grid
  bit model_cells [ROWS][COLS];

  // handshake flags, refreshed at every rising edge, read at the falling edge
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;

  int send_gap     = 0;
  int sink_hold    = 0;
  bit sink_calm    = 1'b0;
  int replies_seen = 0;
  int quiet_cycles = 0;
  int flaws        = 0;

  // stimulus build state
  bit fill_calm  = 1'b0;
  bit drain_next = 1'b0;
  int stim_reqs  = 0;

  // coverage tallies for the closing summary
  int n_write = 0, n_read = 0, n_step = 0, n_unused = 0, n_live_reads = 0;

  life_grid_generation_step dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_step_done  (out_step_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // One B3/S23 generation on the model grid. Neighbours off the edge are dead,
  // so the edges are clipped rather than wrapped.
  function automatic void life_advance();
    bit new_gen [ROWS][COLS];
    int n;
    int rr, cc;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS)
              n += model_cells[rr][cc];
          end
        end
        new_gen[r][c] = (n == BIRTH_CNT) || (model_cells[r][c] && n == KEEP_CNT);
      end
    end
    model_cells = new_gen;
  endfunction

  // Applies one accepted request to the model grid and returns the reply owed.
  function automatic cell_reply_t grid_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] row,
                                             logic [POS_W-1:0] col, logic cell_value);
    cell_reply_t rep;
    bit on_grid;
    rep.read_value = 1'b0;
    rep.step_done  = 1'b0;
    on_grid = (row < ROWS) && (col < COLS);
    case (op)
      OP_WRITE: begin
        n_write++;
        if (on_grid)
          model_cells[row][col] = cell_value;
      end
      OP_READ: begin
        n_read++;
        if (on_grid)
          rep.read_value = model_cells[row][col];
        n_live_reads += rep.read_value;
      end
      OP_STEP: begin
        n_step++;
        life_advance();
        rep.step_done = 1'b1;
      end
      default: begin
        n_unused++;
      end
    endcase
    return rep;
  endfunction

  // Monitor: records both handshakes, predicts on every request taken and
  // checks every reply against the oldest prediction. Also runs the watchdog.
  always @(posedge clk) begin : monitor
    cell_reply_t want;
    req_taken = rst_n && in_valid && !in_stall;
    res_taken = rst_n && out_valid && !out_stall;
    if (req_taken)
      cell_reply_q.push_back(grid_apply(in_op, in_row, in_col, in_cell_value));
    if (res_taken) begin
      if (cell_reply_q.size() == 0) begin
        flaws++;
        if (flaws <= REPORT_MAX)
          $display("%0t: reply with nothing owed: read_value=%b step_done=%b",
                   $realtime, out_read_value, out_step_done);
      end else begin
        want = cell_reply_q.pop_front();
        if (out_read_value !== want.read_value || out_step_done !== want.step_done) begin
          flaws++;
          if (flaws <= REPORT_MAX)
            $display("%0t: reply mismatch: read_value exp %b got %b, step_done exp %b got %b",
                     $realtime, want.read_value, out_read_value,
                     want.step_done, out_step_done);
        end
      end
    end
    if (rst_n) begin
      if (req_taken || res_taken)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake, %0d replies still owed",
                 quiet_cycles, cell_reply_q.size());
        $display("life_grid_generation_step regression: fail");
        $finish;
      end
    end
  end

  // Driver: presents queued requests at the falling edge. A request stays put
  // until taken; after each one a random gap is drawn (none if calm). in_valid
  // gets exactly one assignment per edge so back-to-back requests keep it high.
  always @(negedge clk) begin : driver
    cell_req_t nxt_req;
    logic hold;
    hold = in_valid && !req_taken;
    if (rst_n && !hold) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_pending.size() != 0 &&
                   !(req_pending[0].drain && cell_reply_q.size() != 0)) begin
        nxt_req = req_pending.pop_front();
        in_op         <= nxt_req.op;
        in_row        <= nxt_req.row;
        in_col        <= nxt_req.col;
        in_cell_value <= nxt_req.cell_value;
        send_gap = nxt_req.calm ? 0 : $urandom_range(0, 4);
        hold = 1'b1;
      end
    end
    in_valid <= hold;
  end

  // Sink: after each reply taken, it may stall at random. Every 64 replies
  // it may switch to a calm stretch with no stalls at all.
  always @(negedge clk) begin : sink
    if (res_taken) begin
      replies_seen++;
      if (replies_seen % 64 == 0)
        sink_calm = ($urandom_range(0, 3) == 0);
      sink_hold = sink_calm ? 0 : $urandom_range(0, 4);
    end
    if (rst_n && sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_req(input logic [OP_W-1:0] op, input int r, input int c, input int v);
    cell_req_t q;
    q.op         = op;
    q.row        = r[POS_W-1:0];
    q.col        = c[POS_W-1:0];
    q.cell_value = v[0];
    q.drain      = drain_next;
    q.calm       = fill_calm;
    drain_next   = 1'b0;
    req_pending.push_back(q);
    if (op != OP_UNUSED)
      stim_reqs++;
  endtask

  // Seed a small patch (often against an edge) with random cells, then let it
  // evolve a few generations and probe it with reads. Old contents of the
  // patch partly survive since not every cell is rewritten.
  task automatic seed_and_evolve();
    int h, w, r0, c0, gens;
    h = $urandom_range(3, 6);
    w = $urandom_range(3, 6);
    r0 = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : ROWS - h)
                                     : $urandom_range(0, ROWS - h);
    c0 = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : COLS - w)
                                     : $urandom_range(0, COLS - w);
    for (int i = 0; i < h; i++)
      for (int j = 0; j < w; j++)
        if ($urandom_range(0, 3) != 0)
          push_req(OP_WRITE, r0 + i, c0 + j, $urandom_range(0, 1));
    gens = $urandom_range(1, 4);
    repeat (gens) begin
      push_req(OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      repeat ($urandom_range(2, 5))
        push_req(OP_READ, r0 + $urandom_range(0, h - 1), c0 + $urandom_range(0, w - 1),
                 $urandom_range(0, 1));
    end
  endtask

  initial begin : stimulus
    int pick;

    // --- directed part ---
    fill_calm = 1'b1;
    push_req(OP_READ, 0, 0, 1);             // never written: reset leaves it dead
    push_req(OP_WRITE, 0, 0, 1);            // the four corners
    push_req(OP_WRITE, 0, COLS - 1, 1);
    push_req(OP_WRITE, ROWS - 1, 0, 1);
    push_req(OP_WRITE, ROWS - 1, COLS - 1, 1);
    push_req(OP_READ, ROWS - 1, COLS - 1, 0);
    push_req(OP_STEP, 31, 31, 1);           // advance ignores its fields; lone cells die
    push_req(OP_READ, 0, 0, 0);
    push_req(OP_WRITE, 0, 9, 1);            // blinker lying on the top edge
    push_req(OP_WRITE, 0, 10, 1);
    push_req(OP_WRITE, 0, 11, 1);
    fill_calm = 1'b0;
    push_req(OP_STEP, 0, 0, 0);
    push_req(OP_READ, 0, 10, 0);
    push_req(OP_READ, 1, 10, 1);            // born from three neighbours
    push_req(OP_WRITE, ROWS - 2, COLS - 2, 1);  // block in the bottom-right corner
    push_req(OP_WRITE, ROWS - 2, COLS - 1, 1);
    push_req(OP_WRITE, ROWS - 1, COLS - 2, 1);
    push_req(OP_WRITE, ROWS - 1, COLS - 1, 1);
    drain_next = 1'b1;                      // sender waits for every reply here
    push_req(OP_STEP, 17, 5, 0);
    push_req(OP_READ, ROWS - 1, COLS - 1, 0);
    push_req(OP_WRITE, 1, 10, 0);           // clearing a cell the last advance left dead
    push_req(OP_READ, 1, 10, 1);
    push_req(OP_UNUSED, 31, 31, 1);         // unused op code, all fields high
    push_req(OP_UNUSED, 0, 0, 0);
    push_req(OP_STEP, 21, 10, 1);

    // --- random part: mostly seeded patches left to evolve, some noise ---
    while (stim_reqs < TARGET_REQS) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0)
        fill_calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 39) == 0)
        drain_next = 1'b1;
      if (pick < 55)
        seed_and_evolve();
      else if (pick < 90)
        push_req(OP_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 1));
      else
        push_req(OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
    end

    // reset: held, then released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request to go in and every reply to come back
    while (req_pending.size() != 0 || in_valid || cell_reply_q.size() != 0)
      @(posedge clk);
    // allow for a late advance still sweeping, then look for stray replies
    repeat (ROWS + 8) @(posedge clk);

    flaws += cell_reply_q.size();
    $display("covered %0d writes, %0d reads (%0d live), %0d generation steps, %0d unused ops",
             n_write, n_read, n_live_reads, n_step, n_unused);
    $display("%0d replies checked, %0d mismatches", replies_seen, flaws);
    if (flaws == 0)
      $display("life_grid_generation_step regression: pass");
    else
      $display("life_grid_generation_step regression: fail");
    $finish;
  end

endmodule
